### src/omte_pkg.sv
// ----------------------------------------------------------------------------
// Ordered message table package
// Function codes, status codes and group draw constants.
// ----------------------------------------------------------------------------
package omte_pkg;

   typedef enum logic [2:0] {
      FUNC_ADD     = 3'd0,
      FUNC_EXISTS  = 3'd1,
      FUNC_PENDING = 3'd2,
      FUNC_PAIR    = 3'd3,
      FUNC_MARK    = 3'd4,
      FUNC_SENT    = 3'd5,
      FUNC_COMPACT = 3'd6,
      FUNC_NONE    = 3'd7
   } func_type;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_FAIL = 2'd1;
   localparam logic [1:0] STATUS_ALT  = 2'd2;

   localparam logic [7:0] GROUP_WRAP   = 8'd230;
   localparam logic [7:0] MASTER_EXTRA = 8'd3;

   localparam logic [0:0] CSR_MASTER_MODE = 1'd0;

   typedef struct packed {
      logic [7:0]  group;
      logic [7:0]  op_type;
      logic [15:0] var_id;
      logic [1:0]  direction;
      logic [15:0] byte_len;
      logic [31:0] payload_tag;
      logic [31:0] stamp;
   } slot_type;

endpackage

### src/omte_group_draw.sv
// ----------------------------------------------------------------------------
// Group number draw
// Next group counter value, stepping by one (by four in master mode) and wrapping to one at the limit.
// ----------------------------------------------------------------------------
module omte_group_draw (
   input  logic [7:0] counter,
   input  logic       master_mode,
   output logic [7:0] next_group
);

   always_comb begin
      if (counter >= omte_pkg::GROUP_WRAP) begin
         next_group = 8'd1;
      end else if (master_mode) begin
         next_group = counter + 8'd1 + omte_pkg::MASTER_EXTRA;
      end else begin
         next_group = counter + 8'd1;
      end
   end

endmodule

### src/ordered_message_table_engine.sv
// ----------------------------------------------------------------------------
// Ordered message table engine
// Ordered table of message entries with add, query, mark and compaction.
// ----------------------------------------------------------------------------
// channel | direction | content
// req     | in        | one request: func and message fields
// rsp     | out       | one result per request
// csr     | in/out    | APB register master_mode at address 0
//
// Add, mark sent and the unused code go from accept straight to the output state.
// Queries and mark group walk the table one entry per cycle through a single
// compare unit. Compact walks, then clears the vacated flags. A result stall
// holds the result until rsp_tready; req_tready is low while a request is at
// work or its result waits.
// Synchronous reset clears counts and flags; entry storage is undefined until
// written.
// ----------------------------------------------------------------------------
module ordered_message_table_engine #(
   parameter int DEPTH = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // func[2:0] group[10:3] op_type[18:11] op_type_alt[26:19] var_id[42:27]
   // direction[44:43] byte_len[60:45] payload_tag[92:61] entry_index[96:93]
   input  logic [103:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status[1:0] result_index[5:2] result_group[13:6] result_var[29:14]
   // result_size[45:30] result_tag[77:46] result_time[109:78]
   // entry_count[114:110] removed_count[119:115]
   output logic [119:0] rsp_tdata,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [0:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {S_IDLE, S_WALK, S_TAIL, S_OUT} state_type;

   omte_pkg::slot_type   mem [DEPTH];
   logic [1:0]           flags_ff [DEPTH];

   state_type            state_ff;
   logic                 master_ff;
   logic [CW-1:0]        fill_ff;
   logic [7:0]           gcnt_ff;
   logic [31:0]          time_ff;
   omte_pkg::func_type   func_ff;
   logic [7:0]           grp_ff, typ_ff, typ2_ff;
   logic [15:0]          var_ff;
   logic [1:0]           dir_ff;
   logic [CW-1:0]        rd_ff, wr_ff, rem_ff;
   logic                 found_ff;
   logic [119:0]         out_ff;
   omte_pkg::slot_type   cur_ff;

   logic [7:0]           drawn;
   logic [1:0]           curf;
   logic [IW-1:0]        rd_i, wr_i;

   omte_group_draw u_draw (
      .counter     (gcnt_ff),
      .master_mode (master_ff),
      .next_group  (drawn)
   );

   assign rd_i       = rd_ff[IW-1:0];
   assign wr_i       = wr_ff[IW-1:0];
   assign curf       = flags_ff[rd_i];
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata  = out_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = {31'd0, master_ff};

   function automatic logic [119:0] pack(logic [1:0] st, logic [3:0] ix, logic [7:0] g,
                                          logic [15:0] v, logic [15:0] s, logic [31:0] t,
                                          logic [31:0] tm, logic [4:0] ec, logic [4:0] rc);
      pack = {rc, ec, tm, t, s, v, g, ix, st};
   endfunction

   always_ff @(posedge clock) begin
      if (state_ff == S_WALK) begin
         cur_ff <= mem[rd_i + IW'(1)];
      end else begin
         cur_ff <= mem[0];
      end
      if (state_ff == S_WALK && rd_ff < fill_ff && func_ff == omte_pkg::FUNC_COMPACT
          && !curf[1] && wr_ff != rd_ff) begin
         mem[wr_i] <= cur_ff;
      end else if (state_ff == S_IDLE && req_tvalid && req_tdata[2:0] == omte_pkg::FUNC_ADD
                   && fill_ff < CW'(DEPTH)) begin
         mem[fill_ff[IW-1:0]] <= '{
            group:        (req_tdata[10:3] == 8'd0) ? drawn : req_tdata[10:3],
            op_type:      req_tdata[18:11],
            var_id:       req_tdata[42:27],
            direction:    req_tdata[44:43],
            byte_len:     req_tdata[60:45],
            payload_tag:  req_tdata[92:61],
            stamp:        time_ff + 32'd1};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         master_ff <= 1'b0;
         fill_ff   <= '0;
         gcnt_ff   <= '0;
         time_ff   <= '0;
         for (int i = 0; i < DEPTH; i++) flags_ff[i] <= 2'b00;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_paddr == omte_pkg::CSR_MASTER_MODE)
            master_ff <= csr_pwdata[0];
         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  func_ff  <= omte_pkg::func_type'(req_tdata[2:0]);
                  grp_ff   <= req_tdata[10:3];
                  typ_ff   <= req_tdata[18:11];
                  typ2_ff  <= req_tdata[26:19];
                  var_ff   <= req_tdata[42:27];
                  dir_ff   <= req_tdata[44:43];
                  rd_ff    <= '0;
                  wr_ff    <= '0;
                  rem_ff   <= '0;
                  found_ff <= 1'b0;
                  unique case (req_tdata[2:0])
                     omte_pkg::FUNC_ADD: begin
                        state_ff <= S_OUT;
                        if (req_tdata[10:3] == 8'd0) gcnt_ff <= drawn;
                        if (fill_ff < CW'(DEPTH)) begin
                           flags_ff[fill_ff[IW-1:0]] <= 2'b00;
                           fill_ff <= fill_ff + 1'b1;
                           time_ff <= time_ff + 32'd1;
                           out_ff <= pack(omte_pkg::STATUS_OK, 4'(fill_ff),
                              (req_tdata[10:3] == 8'd0) ? drawn : req_tdata[10:3],
                              '0, '0, '0, time_ff + 32'd1, 5'(fill_ff + 1'b1), '0);
                        end else begin
                           out_ff <= pack(omte_pkg::STATUS_FAIL, '0,
                              (req_tdata[10:3] == 8'd0) ? drawn : req_tdata[10:3],
                              '0, '0, '0, '0, 5'(fill_ff), '0);
                        end
                     end
                     omte_pkg::FUNC_SENT: begin
                        state_ff <= S_OUT;
                        if (32'(req_tdata[96:93]) < 32'(fill_ff)) begin
                           flags_ff[IW'(req_tdata[96:93])] <= 2'b01;
                           out_ff <= pack(omte_pkg::STATUS_OK, req_tdata[96:93], '0, '0,
                                          '0, '0, '0, 5'(fill_ff), '0);
                        end else begin
                           out_ff <= pack(omte_pkg::STATUS_FAIL, '0, '0, '0, '0, '0, '0,
                                          5'(fill_ff), '0);
                        end
                     end
                     omte_pkg::FUNC_NONE: begin
                        state_ff <= S_OUT;
                        out_ff <= pack(omte_pkg::STATUS_FAIL, '0, '0, '0, '0, '0, '0,
                                       5'(fill_ff), '0);
                     end
                     default: begin
                        state_ff <= S_WALK;
                        out_ff <= pack(omte_pkg::STATUS_FAIL, '0, '0, '0, '0, '0, '0,
                                       5'(fill_ff), '0);
                     end
                  endcase
               end
            end
            S_WALK: begin
               if (rd_ff >= fill_ff || found_ff) begin
                  case (func_ff)
                     omte_pkg::FUNC_MARK: begin
                        if (fill_ff != '0) out_ff[1:0] <= omte_pkg::STATUS_OK;
                        state_ff <= S_OUT;
                     end
                     omte_pkg::FUNC_COMPACT: state_ff <= S_TAIL;
                     default: state_ff <= S_OUT;
                  endcase
               end else begin
                  rd_ff <= rd_ff + 1'b1;
                  case (func_ff)
                     omte_pkg::FUNC_EXISTS, omte_pkg::FUNC_PENDING: begin
                        if (!curf[1] && !(func_ff == omte_pkg::FUNC_PENDING && curf[0])
                            && cur_ff.var_id == var_ff && cur_ff.op_type == typ_ff
                            && cur_ff.direction == dir_ff) begin
                           found_ff <= 1'b1;
                           out_ff <= pack(omte_pkg::STATUS_OK, 4'(rd_ff), cur_ff.group,
                              cur_ff.var_id, cur_ff.byte_len, cur_ff.payload_tag,
                              cur_ff.stamp, 5'(fill_ff), '0);
                        end
                     end
                     omte_pkg::FUNC_PAIR: begin
                        if (cur_ff.group == grp_ff && cur_ff.direction == dir_ff &&
                            (cur_ff.op_type == typ_ff || cur_ff.op_type == typ2_ff)) begin
                           found_ff <= 1'b1;
                           out_ff <= pack((cur_ff.op_type == typ_ff) ? omte_pkg::STATUS_OK
                              : omte_pkg::STATUS_ALT, 4'(rd_ff), cur_ff.group,
                              cur_ff.var_id, cur_ff.byte_len, cur_ff.payload_tag,
                              cur_ff.stamp, 5'(fill_ff), '0);
                        end
                     end
                     omte_pkg::FUNC_MARK: begin
                        if (cur_ff.group == grp_ff) flags_ff[rd_i] <= curf | 2'b10;
                     end
                     omte_pkg::FUNC_COMPACT: begin
                        if (curf[1]) begin
                           rem_ff <= rem_ff + 1'b1;
                        end else begin
                           flags_ff[wr_i] <= curf;
                           wr_ff <= wr_ff + 1'b1;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            S_TAIL: begin
               if (wr_ff < fill_ff) begin
                  flags_ff[wr_i] <= 2'b00;
                  wr_ff <= wr_ff + 1'b1;
               end else begin
                  fill_ff <= fill_ff - rem_ff;
                  out_ff <= pack(omte_pkg::STATUS_OK, '0, '0, '0, '0, '0, '0,
                                 5'(fill_ff - rem_ff), 5'(rem_ff));
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (rsp_tready) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule
